FILE: src/tlc_pkg.sv
// package: geometry, payload structs, row types and lru helpers for the two-level cache model
package tlc_pkg;

  localparam int unsigned BLOCK_LOG2   = 6;
  localparam int unsigned L1_SIZE_LOG2 = 15;
  localparam int unsigned L1_WAYS_LOG2 = 2;
  localparam int unsigned L2_SIZE_LOG2 = 18;
  localparam int unsigned L2_WAYS_LOG2 = 3;
  localparam int unsigned ADDR_W       = 32;

  localparam int unsigned L1_WAYS  = 1 << L1_WAYS_LOG2;
  localparam int unsigned L1_SET_W = L1_SIZE_LOG2 - BLOCK_LOG2 - L1_WAYS_LOG2;
  localparam int unsigned L1_TAG_LSB = L1_SIZE_LOG2 - L1_WAYS_LOG2;
  localparam int unsigned L1_TAG_W = ADDR_W - L1_TAG_LSB;
  localparam int unsigned L1_AGE_W = (L1_WAYS_LOG2 > 0) ? L1_WAYS_LOG2 : 1;
  localparam int unsigned L1_WAY_W = (L1_WAYS_LOG2 > 0) ? L1_WAYS_LOG2 : 1;

  localparam int unsigned L2_WAYS  = 1 << L2_WAYS_LOG2;
  localparam int unsigned L2_SET_W = L2_SIZE_LOG2 - BLOCK_LOG2 - L2_WAYS_LOG2;
  localparam int unsigned L2_TAG_LSB = L2_SIZE_LOG2 - L2_WAYS_LOG2;
  localparam int unsigned L2_TAG_W = ADDR_W - L2_TAG_LSB;
  localparam int unsigned L2_AGE_W = (L2_WAYS_LOG2 > 0) ? L2_WAYS_LOG2 : 1;
  localparam int unsigned L2_WAY_W = (L2_WAYS_LOG2 > 0) ? L2_WAYS_LOG2 : 1;

  localparam int unsigned CYC_W = 13;
  localparam int unsigned CNT_W = 32;

  // configuration register indexes
  localparam logic [2:0] CFG_L1_LAT  = 3'd0;
  localparam logic [2:0] CFG_L2_LAT  = 3'd1;
  localparam logic [2:0] CFG_MEM_LAT = 3'd2;
  localparam logic [2:0] CFG_WR_ALLOC = 3'd3;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
  } tlc_req_t;

  typedef struct packed {
    logic             l1_hit;
    logic             l2_accessed;
    logic             l2_hit;
    logic [CYC_W-1:0] access_cycles;
    logic [CNT_W-1:0] l1_access_total;
    logic [CNT_W-1:0] l1_miss_total;
    logic [CNT_W-1:0] l2_access_total;
    logic [CNT_W-1:0] l2_miss_total;
    logic [CNT_W-1:0] cycle_total;
  } tlc_rsp_t;

  typedef struct packed {
    logic [L1_TAG_W-1:0] tag;
    logic                valid;
    logic                dirty;
    logic [L1_AGE_W-1:0] age;
  } l1_way_t;

  typedef struct packed {
    logic [L2_TAG_W-1:0] tag;
    logic                valid;
    logic                dirty;
    logic [L2_AGE_W-1:0] age;
  } l2_way_t;

  typedef l1_way_t [L1_WAYS-1:0] l1_row_t;
  typedef l2_way_t [L2_WAYS-1:0] l2_row_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  // first valid way with a matching tag; {hit, way}
  function automatic logic [L1_WAY_W:0] l1_lookup(input l1_row_t r,
                                                  input logic [L1_TAG_W-1:0] t);
    logic [L1_WAY_W:0] res;
    res = '0;
    for (int j = L1_WAYS - 1; j >= 0; j--) begin
      if (r[j].valid && r[j].tag == t) res = {1'b1, L1_WAY_W'(j)};
    end
    return res;
  endfunction

  function automatic logic [L2_WAY_W:0] l2_lookup(input l2_row_t r,
                                                  input logic [L2_TAG_W-1:0] t);
    logic [L2_WAY_W:0] res;
    res = '0;
    for (int j = L2_WAYS - 1; j >= 0; j--) begin
      if (r[j].valid && r[j].tag == t) res = {1'b1, L2_WAY_W'(j)};
    end
    return res;
  endfunction

  // first invalid or oldest way, else the last way
  function automatic logic [L1_WAY_W-1:0] l1_pick(input l1_row_t r);
    logic [L1_WAY_W-1:0] w;
    w = L1_WAY_W'(L1_WAYS - 1);
    for (int j = L1_WAYS - 1; j >= 0; j--) begin
      if (!r[j].valid || r[j].age == L1_AGE_W'(L1_WAYS - 1)) w = L1_WAY_W'(j);
    end
    return w;
  endfunction

  function automatic logic [L2_WAY_W-1:0] l2_pick(input l2_row_t r);
    logic [L2_WAY_W-1:0] w;
    w = L2_WAY_W'(L2_WAYS - 1);
    for (int j = L2_WAYS - 1; j >= 0; j--) begin
      if (!r[j].valid || r[j].age == L2_AGE_W'(L2_WAYS - 1)) w = L2_WAY_W'(j);
    end
    return w;
  endfunction

  // make a way most recently used
  function automatic l1_row_t l1_touch(input l1_row_t r, input logic [L1_WAY_W-1:0] w);
    l1_row_t o;
    logic    wv;
    logic [L1_AGE_W-1:0] wa;
    o  = r;
    wv = r[w].valid;
    wa = r[w].age;
    for (int j = 0; j < L1_WAYS; j++) begin
      if (L1_WAY_W'(j) != w && r[j].valid && (!wv || r[j].age < wa))
        o[j].age = L1_AGE_W'((r[j].age + 1'b1) & L1_AGE_W'(L1_WAYS - 1));
    end
    o[w].age   = '0;
    o[w].valid = 1'b1;
    return o;
  endfunction

  function automatic l2_row_t l2_touch(input l2_row_t r, input logic [L2_WAY_W-1:0] w);
    l2_row_t o;
    logic    wv;
    logic [L2_AGE_W-1:0] wa;
    o  = r;
    wv = r[w].valid;
    wa = r[w].age;
    for (int j = 0; j < L2_WAYS; j++) begin
      if (L2_WAY_W'(j) != w && r[j].valid && (!wv || r[j].age < wa))
        o[j].age = L2_AGE_W'((r[j].age + 1'b1) & L2_AGE_W'(L2_WAYS - 1));
    end
    o[w].age   = '0;
    o[w].valid = 1'b1;
    return o;
  endfunction

  // invalidate a way and close the gap in the age ranks
  function automatic l1_row_t l1_drop(input l1_row_t r, input logic [L1_WAY_W-1:0] w);
    l1_row_t o;
    o = r;
    for (int j = 0; j < L1_WAYS; j++) begin
      if (L1_WAY_W'(j) != w && r[j].valid && r[j].age > r[w].age)
        o[j].age = r[j].age - 1'b1;
    end
    o[w].valid = 1'b0;
    return o;
  endfunction

endpackage

FILE: src/two_level_cache_tag_lru_model.sv
// top level: sequenced tag/lru state machine of an inclusive two-level cache
// on an l1 hit the fsm runs ST_L1 then ST_DONE; an l1 miss adds ST_L2, and a dirty
//   l1 victim adds ST_VRD, ST_VUPD; one transaction at a time, busy high meanwhile
// the steps come from the single registered read port of each set memory: l1 row, l2 row,
//   then the victim's l2 row are fetched one after another
// reset: asynchronous active low; then a clearing pass over every row of both set memories
//   with busy high; results are strobed for one cycle on done_o and cannot be stalled
module two_level_cache_tag_lru_model
  import tlc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  tlc_req_t    req_i,
  output logic        done_o,
  output tlc_rsp_t    rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_L1   = 3'd2;
  localparam logic [2:0] ST_L2   = 3'd3;
  localparam logic [2:0] ST_VRD  = 3'd4;
  localparam logic [2:0] ST_VUPD = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam int unsigned L1_ROWS = 1 << L1_SET_W;
  localparam int unsigned L2_ROWS = 1 << L2_SET_W;

  // set memories, one row per set holding all ways
  l1_row_t l1_mem [L1_ROWS];
  l2_row_t l2_mem [L2_ROWS];

  logic [2:0] state_q, state_d;
  logic [L2_SET_W-1:0] clr_q, clr_d;

  // configuration
  logic [7:0]  l1_lat_q;
  logic [9:0]  l2_lat_q;
  logic [11:0] mem_lat_q;
  logic        wr_alloc_q;

  // transaction context
  logic              kind_q, kind_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  l1_row_t           l1row_q, l1row_d;
  logic [CYC_W-1:0]  cyc_q, cyc_d;
  logic              hit1_q, hit1_d, acc2_q, acc2_d, hit2_q, hit2_d;
  logic [L2_SET_W-1:0] vs_q, vs_d;
  logic [L2_TAG_W-1:0] vtag_q, vtag_d;

  // running counters
  logic [CNT_W-1:0] acc1_cnt_q, acc1_cnt_d, miss1_cnt_q, miss1_cnt_d;
  logic [CNT_W-1:0] acc2_cnt_q, acc2_cnt_d, miss2_cnt_q, miss2_cnt_d;
  logic [CNT_W-1:0] lat_sum_q, lat_sum_d;

  logic     done_q, done_d;
  tlc_rsp_t rsp_q, rsp_d;

  // memory ports
  logic                l1_we, l2_we;
  logic [L1_SET_W-1:0] l1_raddr, l1_waddr;
  logic [L2_SET_W-1:0] l2_raddr, l2_waddr;
  l1_row_t             l1_wdata, l1_rd_q;
  l2_row_t             l2_wdata, l2_rd_q;

  always_ff @(posedge clk_i) begin
    if (l1_we) l1_mem[l1_waddr] <= l1_wdata;
    l1_rd_q <= l1_mem[l1_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (l2_we) l2_mem[l2_waddr] <= l2_wdata;
    l2_rd_q <= l2_mem[l2_raddr];
  end

  // address fields of the current transaction
  logic [L1_SET_W-1:0] s1;
  logic [L1_TAG_W-1:0] t1;
  logic [L2_SET_W-1:0] s2;
  logic [L2_TAG_W-1:0] t2;
  assign s1 = addr_q[BLOCK_LOG2 +: L1_SET_W];
  assign t1 = addr_q[ADDR_W-1:L1_TAG_LSB];
  assign s2 = addr_q[BLOCK_LOG2 +: L2_SET_W];
  assign t2 = addr_q[ADDR_W-1:L2_TAG_LSB];

  // shared lookup / replacement logic
  logic [L1_WAY_W:0]   lk1;
  logic [L2_WAY_W:0]   lk2;
  logic [L2_WAY_W:0]   lkv;
  logic [L1_WAY_W:0]   lke;
  logic [L2_WAY_W-1:0] fw;
  logic [L1_WAY_W-1:0] nv;
  logic                evict;
  logic [ADDR_W-1:0]   ea, va;
  l1_row_t             r1, r1_drop;
  l2_row_t             r2, r2v;

  always_comb begin
    lk1 = l1_lookup(l1_rd_q, t1);
    lk2 = l2_lookup(l2_rd_q, t2);
    lkv = l2_lookup(l2_rd_q, vtag_q);
    // fill way in l2 and the block it pushes out
    fw    = lk2[L2_WAY_W] ? lk2[L2_WAY_W-1:0] : l2_pick(l2_rd_q);
    evict = !lk2[L2_WAY_W] && l2_rd_q[fw].valid;
    ea    = {l2_rd_q[fw].tag, s2, BLOCK_LOG2'(0)};
    // the evicted block maps to the same l1 set as this access (l1 index bits lie
    // inside the l2 index bits), so the back-invalidate searches the held l1 row
    lke     = l1_lookup(l1row_q, ea[ADDR_W-1:L1_TAG_LSB]);
    r1_drop = (evict && lke[L1_WAY_W]) ? l1_drop(l1row_q, lke[L1_WAY_W-1:0]) : l1row_q;
    nv      = l1_pick(r1_drop);
    va      = {r1_drop[nv].tag, s1, BLOCK_LOG2'(0)};
    // l2 row after the fill / touch
    r2 = l2_rd_q;
    if (!lk2[L2_WAY_W]) begin
      r2[fw].tag   = t2;
      r2[fw].dirty = 1'b0;
    end
    r2 = l2_touch(r2, fw);
    // l1 row after the refill
    r1 = r1_drop;
    r1[nv].tag   = t1;
    r1[nv].dirty = kind_q;
    r1 = l1_touch(r1, nv);
    // victim's l2 copy turns dirty and most recently used
    r2v = l2_rd_q;
    r2v[lkv[L2_WAY_W-1:0]].dirty = 1'b1;
    r2v = l2_touch(r2v, lkv[L2_WAY_W-1:0]);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    kind_d      = kind_q;
    addr_d      = addr_q;
    l1row_d     = l1row_q;
    cyc_d       = cyc_q;
    hit1_d      = hit1_q;
    acc2_d      = acc2_q;
    hit2_d      = hit2_q;
    vs_d        = vs_q;
    vtag_d      = vtag_q;
    acc1_cnt_d  = acc1_cnt_q;
    miss1_cnt_d = miss1_cnt_q;
    acc2_cnt_d  = acc2_cnt_q;
    miss2_cnt_d = miss2_cnt_q;
    lat_sum_d   = lat_sum_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    l1_we       = 1'b0;
    l2_we       = 1'b0;
    l1_raddr    = s1;
    l1_waddr    = s1;
    l2_raddr    = s2;
    l2_waddr    = s2;
    l1_wdata    = r1;
    l2_wdata    = r2;

    case (state_q)
      ST_CLR: begin
        // wipe valid, dirty and age of every set
        l1_we    = 1'b1;
        l2_we    = 1'b1;
        l1_waddr = clr_q[L1_SET_W-1:0];
        l2_waddr = clr_q;
        l1_wdata = '0;
        l2_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == L2_SET_W'(L2_ROWS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        l1_raddr = req_i.address[BLOCK_LOG2 +: L1_SET_W];
        if (start) begin
          kind_d  = req_i.kind;
          addr_d  = req_i.address;
          cyc_d   = CYC_W'(l1_lat_q);
          hit1_d  = 1'b0;
          acc2_d  = 1'b0;
          hit2_d  = 1'b0;
          state_d = ST_L1;
        end
      end
      ST_L1: begin
        acc1_cnt_d = sat_add(acc1_cnt_q, CNT_W'(1));
        l1row_d    = l1_rd_q;
        if (lk1[L1_WAY_W]) begin
          // l1 hit: touch, mark dirty on a write
          hit1_d   = 1'b1;
          l1_we    = 1'b1;
          l1_wdata = l1_rd_q;
          if (kind_q) l1_wdata[lk1[L1_WAY_W-1:0]].dirty = 1'b1;
          l1_wdata = l1_touch(l1_wdata, lk1[L1_WAY_W-1:0]);
          state_d  = ST_DONE;
        end else begin
          acc2_d      = 1'b1;
          miss1_cnt_d = sat_add(miss1_cnt_q, CNT_W'(1));
          acc2_cnt_d  = sat_add(acc2_cnt_q, CNT_W'(1));
          cyc_d       = cyc_q + CYC_W'(l2_lat_q);
          state_d     = ST_L2;
        end
      end
      ST_L2: begin
        hit2_d = lk2[L2_WAY_W];
        if (!lk2[L2_WAY_W]) begin
          cyc_d       = cyc_q + CYC_W'(mem_lat_q);
          miss2_cnt_d = sat_add(miss2_cnt_q, CNT_W'(1));
        end
        state_d = ST_DONE;
        if (kind_q && !wr_alloc_q) begin
          // write miss without allocation: only an l2 hit is marked
          if (lk2[L2_WAY_W]) begin
            l2_we    = 1'b1;
            l2_wdata = l2_rd_q;
            l2_wdata[lk2[L2_WAY_W-1:0]].dirty = 1'b1;
            l2_wdata = l2_touch(l2_wdata, lk2[L2_WAY_W-1:0]);
          end
        end else begin
          l2_we = 1'b1;
          l1_we = 1'b1;
          if (r1_drop[nv].valid && r1_drop[nv].dirty) begin
            vs_d    = va[BLOCK_LOG2 +: L2_SET_W];
            vtag_d  = va[ADDR_W-1:L2_TAG_LSB];
            state_d = ST_VRD;
          end
        end
      end
      ST_VRD: begin
        // l2 write of the previous cycle is visible to this read
        l2_raddr = vs_q;
        state_d  = ST_VUPD;
      end
      ST_VUPD: begin
        l2_waddr = vs_q;
        l2_wdata = r2v;
        l2_we    = lkv[L2_WAY_W];
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        lat_sum_d           = sat_add(lat_sum_q, CNT_W'(cyc_q));
        done_d              = 1'b1;
        rsp_d.l1_hit        = hit1_q;
        rsp_d.l2_accessed   = acc2_q;
        rsp_d.l2_hit        = hit2_q;
        rsp_d.access_cycles = cyc_q;
        rsp_d.l1_access_total = acc1_cnt_q;
        rsp_d.l1_miss_total   = miss1_cnt_q;
        rsp_d.l2_access_total = acc2_cnt_q;
        rsp_d.l2_miss_total   = miss2_cnt_q;
        rsp_d.cycle_total     = lat_sum_d;
        state_d               = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      l1_lat_q    <= 8'd1;
      l2_lat_q    <= 10'd5;
      mem_lat_q   <= 12'd100;
      wr_alloc_q  <= 1'b1;
      acc1_cnt_q  <= '0;
      miss1_cnt_q <= '0;
      acc2_cnt_q  <= '0;
      miss2_cnt_q <= '0;
      lat_sum_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      acc1_cnt_q  <= acc1_cnt_d;
      miss1_cnt_q <= miss1_cnt_d;
      acc2_cnt_q  <= acc2_cnt_d;
      miss2_cnt_q <= miss2_cnt_d;
      lat_sum_q   <= lat_sum_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_L1_LAT:   l1_lat_q   <= cfg_wdata_i[7:0];
          CFG_L2_LAT:   l2_lat_q   <= cfg_wdata_i[9:0];
          CFG_MEM_LAT:  mem_lat_q  <= cfg_wdata_i;
          CFG_WR_ALLOC: wr_alloc_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // transaction payload, no reset needed
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    addr_q  <= addr_d;
    l1row_q <= l1row_d;
    cyc_q   <= cyc_d;
    hit1_q  <= hit1_d;
    acc2_q  <= acc2_d;
    hit2_q  <= hit2_d;
    vs_q    <= vs_d;
    vtag_q  <= vtag_d;
    rsp_q   <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
